[rtl/base64_framed_log_encoder_unit_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the framed Base64 log encoder
// Shared concurrent-check forms, clocked on clk and gated by arst_n.
// ---------------------------------------------------------------------------
`ifndef BASE64_FRAMED_LOG_ENCODER_UNIT_MACROS_SVH
`define BASE64_FRAMED_LOG_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication
`define B64FLE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define B64FLE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/b64fle_pkg.sv]
// ---------------------------------------------------------------------------
// b64fle_pkg
// Types, character codes and the Base64 alphabet for the framed encoder.
// ---------------------------------------------------------------------------
package b64fle_pkg;

	// Framing and pad characters
	localparam logic [7:0] CH_START = 8'h24;
	localparam logic [7:0] CH_PAD   = 8'h3D;
	localparam logic [7:0] CH_NL    = 8'h0A;

	// Position within a 3-byte group
	localparam logic [1:0] PH_ZERO = 2'd0;
	localparam logic [1:0] PH_ONE  = 2'd1;
	localparam logic [1:0] PH_TWO  = 2'd2;

	// Most characters a single item can produce
	localparam int MAX_CHARS = 6;
	localparam int CNT_W     = 3;

	// Default depth of the job queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// One classified item: the characters it yields, in order
	typedef struct packed {
		logic [MAX_CHARS-1:0][7:0] chars;
		logic [CNT_W-1:0]          count;   // number of valid chars, 1..6
		logic                      closes;  // last char is the closing newline
	} job_t;

	// Base64 alphabet A-Z a-z 0-9 + /
	function automatic logic [7:0] b64_sym(input logic [5:0] v);
		logic [7:0] c;
		begin
			if (v < 6'd26)
				c = 8'h41 + {2'b00, v};
			else if (v < 6'd52)
				c = 8'h61 + {2'b00, v - 6'd26};
			else if (v < 6'd62)
				c = 8'h30 + {2'b00, v - 6'd52};
			else if (v == 6'd62)
				c = 8'h2B;
			else
				c = 8'h2F;
			return c;
		end
	endfunction

endpackage

[rtl/b64fle_front.sv]
// ---------------------------------------------------------------------------
// b64fle_front
// Accepts input items, tracks message/group state and turns each item into
// a job holding all the characters it produces.
// ---------------------------------------------------------------------------
module b64fle_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [7:0]         s_axis_tdata,   // [7:0] data_byte
	input  logic               s_axis_tlast,   // last_byte
	input  logic               s_axis_tuser,   // empty_message
	input  logic               queue_full,
	output logic               push,
	output b64fle_pkg::job_t   push_job
);

	logic       in_message_q;
	logic [1:0] phase_q;
	logic [3:0] left_q;

	logic [1:0] ph;
	logic [3:0] lo;
	logic [1:0] nph;
	logic [3:0] nlo;
	logic       closes;
	logic [b64fle_pkg::CNT_W-1:0] n;
	logic [b64fle_pkg::MAX_CHARS-1:0][7:0] ch;

	assign s_axis_tready = !queue_full;
	assign push          = s_axis_tvalid && s_axis_tready;

	// Build the character list for the offered item
	always_comb begin
		ph     = in_message_q ? phase_q : b64fle_pkg::PH_ZERO;
		lo     = in_message_q ? left_q : 4'd0;
		nph    = ph;
		nlo    = lo;
		closes = s_axis_tuser || s_axis_tlast;
		n      = '0;
		ch     = '0;

		if (!in_message_q) begin
			ch[n] = b64fle_pkg::CH_START;
			n     = n + 3'd1;
		end

		// Payload byte
		if (!s_axis_tuser) begin
			unique case (ph)
				b64fle_pkg::PH_ONE: begin
					ch[n] = b64fle_pkg::b64_sym({lo[1:0], s_axis_tdata[7:4]});
					n     = n + 3'd1;
					nlo   = s_axis_tdata[3:0];
					nph   = b64fle_pkg::PH_TWO;
				end
				b64fle_pkg::PH_TWO: begin
					ch[n] = b64fle_pkg::b64_sym({lo, s_axis_tdata[7:6]});
					n     = n + 3'd1;
					ch[n] = b64fle_pkg::b64_sym(s_axis_tdata[5:0]);
					n     = n + 3'd1;
					nlo   = 4'd0;
					nph   = b64fle_pkg::PH_ZERO;
				end
				default: begin
					// phase zero, and the unused phase three
					ch[n] = b64fle_pkg::b64_sym(s_axis_tdata[7:2]);
					n     = n + 3'd1;
					nlo   = {2'b00, s_axis_tdata[1:0]};
					nph   = b64fle_pkg::PH_ONE;
				end
			endcase
		end

		// Flush pending group with padding, then newline
		if (closes) begin
			unique case (nph)
				b64fle_pkg::PH_ONE: begin
					ch[n] = b64fle_pkg::b64_sym({nlo[1:0], 4'd0});
					n     = n + 3'd1;
					ch[n] = b64fle_pkg::CH_PAD;
					n     = n + 3'd1;
					ch[n] = b64fle_pkg::CH_PAD;
					n     = n + 3'd1;
				end
				b64fle_pkg::PH_TWO: begin
					ch[n] = b64fle_pkg::b64_sym({nlo, 2'd0});
					n     = n + 3'd1;
					ch[n] = b64fle_pkg::CH_PAD;
					n     = n + 3'd1;
				end
				default: begin
				end
			endcase
			ch[n] = b64fle_pkg::CH_NL;
			n     = n + 3'd1;
		end

		push_job.chars  = ch;
		push_job.count  = n;
		push_job.closes = closes;
	end

	// Message state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_message_q <= 1'b0;
			phase_q      <= b64fle_pkg::PH_ZERO;
			left_q       <= 4'd0;
		end else if (push) begin
			if (closes) begin
				in_message_q <= 1'b0;
				phase_q      <= b64fle_pkg::PH_ZERO;
				left_q       <= 4'd0;
			end else begin
				in_message_q <= 1'b1;
				phase_q      <= nph;
				left_q       <= nlo;
			end
		end
	end

`include "base64_framed_log_encoder_unit_macros.svh"

	`B64FLE_ASSERT_NEXT(a_close_clears, push && closes, !in_message_q && left_q == 4'd0, "message still open after close")

endmodule

[rtl/b64fle_queue.sv]
// ---------------------------------------------------------------------------
// b64fle_queue
// Short job FIFO decoupling the classifier from the character emitter.
// ---------------------------------------------------------------------------
module b64fle_queue #(
	parameter int DEPTH = b64fle_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  b64fle_pkg::job_t push_job,
	output logic             full,
	input  logic             pop,
	output b64fle_pkg::job_t head_job,
	output logic             head_valid
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	b64fle_pkg::job_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

`include "base64_framed_log_encoder_unit_macros.svh"

	`B64FLE_ASSERT_NOW(a_no_overflow, push, !full, "push into full queue")
	`B64FLE_ASSERT_NOW(a_no_underflow, pop, head_valid, "pop from empty queue")
	`B64FLE_ASSERT_NOW(a_count_range, 1'b1, count_q <= CW'(DEPTH), "fill count out of range")

endmodule

[rtl/b64fle_back.sv]
// ---------------------------------------------------------------------------
// b64fle_back
// Walks the head job into the output register one character per cycle while the output is not stalled.
// ---------------------------------------------------------------------------
module b64fle_back (
	input  logic             clk,
	input  logic             arst_n,
	input  b64fle_pkg::job_t head_job,
	input  logic             head_valid,
	output logic             pop,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [7:0]       m_axis_tdata,   // [7:0] out_char
	output logic             m_axis_tlast    // last_char
);

	logic [b64fle_pkg::CNT_W-1:0] idx_q;
	logic       tvalid_q;
	logic [7:0] tdata_q;
	logic       tlast_q;
	logic       load;
	logic       at_end;

	assign load   = head_valid && (!tvalid_q || m_axis_tready);
	assign at_end = (idx_q == head_job.count - 3'd1);
	assign pop    = load && at_end;

	assign m_axis_tvalid = tvalid_q;
	assign m_axis_tdata  = tdata_q;
	assign m_axis_tlast  = tlast_q;

	// Output payload
	always_ff @(posedge clk) begin
		if (load) begin
			tdata_q <= head_job.chars[idx_q];
			tlast_q <= head_job.closes && at_end;
		end
	end

	// Character index and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			tvalid_q <= 1'b0;
		end else begin
			if (load)
				idx_q <= at_end ? '0 : idx_q + 3'd1;
			if (load)
				tvalid_q <= 1'b1;
			else if (m_axis_tready)
				tvalid_q <= 1'b0;
		end
	end

`include "base64_framed_log_encoder_unit_macros.svh"

	`B64FLE_ASSERT_NOW(a_last_is_nl, m_axis_tvalid && m_axis_tlast, m_axis_tdata == b64fle_pkg::CH_NL, "last char is not a newline")

endmodule

[rtl/base64_framed_log_encoder_unit.sv]
// ---------------------------------------------------------------------------
// base64_framed_log_encoder_unit
// Framed Base64 log encoder: '$', RFC 4648 Base64 of the payload, newline.
// ---------------------------------------------------------------------------
// Channel   Dir  tdata              tlast       tuser
// s_axis    in   data_byte [7:0]    last_byte   empty_message
// m_axis    out  out_char  [7:0]    last_char   -
//
// One item yields 1 to 6 characters; the emitter sends one character per
// cycle while the output is not stalled. The front accepts an item every
// cycle while the job queue (QUEUE_DEPTH entries) has room. Reset is
// asynchronous, active low, with no clearing pass. Either side may stall;
// the queue and output register absorb it.
module base64_framed_log_encoder_unit #(
	parameter int QUEUE_DEPTH = b64fle_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  logic       s_axis_tlast,   // last_byte
	input  logic       s_axis_tuser,   // empty_message
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_char
	output logic       m_axis_tlast    // last_char
);

	logic             queue_full;
	logic             push;
	b64fle_pkg::job_t push_job;
	logic             pop;
	b64fle_pkg::job_t head_job;
	logic             head_valid;

	// Classifier
	b64fle_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.queue_full    (queue_full),
		.push          (push),
		.push_job      (push_job)
	);

	// Job queue
	b64fle_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (queue_full),
		.pop        (pop),
		.head_job   (head_job),
		.head_valid (head_valid)
	);

	// Character emitter
	b64fle_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_job      (head_job),
		.head_valid    (head_valid),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
